>>> rtl/core/itot_pkg.sv
// Shared types and constants of the inverse-time overload trip core.
// Payload structs, datapath operation codes and fixed-point constants.
// No dependencies.
package itot_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DEN_W      = 52;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIP_CURRENT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_CONSTANT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COOL_TIME      = 2'd2;

  localparam logic [15:0] TRIP_CURRENT_RST   = 16'd1000;
  localparam logic [31:0] CURVE_CONSTANT_RST = 32'd65536;
  localparam logic [31:0] COOL_TIME_RST      = 32'd655360;

  localparam logic [23:0] PICKUP_Q816 = 24'd75366;
  localparam logic [23:0] RATIO_MAX   = 24'hFF_FFFF;
  localparam logic [31:0] ENERGY_ONE  = 32'h8000_0000;
  localparam logic [19:0] US_PER_S    = 20'd1000000;

  localparam int unsigned RATIO_ITER  = 32;
  localparam int unsigned ENERGY_ITER = 31;

  typedef struct packed {
    logic [15:0] current_sample;
  } sample_t;

  typedef struct packed {
    logic        tripped;
    logic [31:0] energy_level;
    logic        above_pickup;
  } result_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV,
    OP_RATIO,
    OP_SQUARE,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_SETUP,
    OP_UPDATE
  } dp_op_e;

  typedef struct packed {
    logic tripped;
  } dp_status_t;

endpackage

>>> rtl/core/itot_stream_if.sv
// Valid/ready stream channel carrying one payload item per handshake.
// The payload type is set at instantiation; no dependencies.
interface itot_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

>>> rtl/core/itot_dpath.sv
// Datapath of the overload trip core: configuration registers, shared restoring
// divider, multipliers, energy accumulator and result register.
// Depends on itot_pkg; driven by operation codes from itot_ctrl.
module itot_dpath #(
  parameter int unsigned TICK_PERIOD_US = 10000
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  itot_pkg::dp_op_e                op_i,
  input  itot_pkg::sample_t               sample_i,
  input  logic                            cfg_we_i,
  input  logic [itot_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [itot_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output itot_pkg::dp_status_t            status_o,
  output itot_pkg::result_t               result_o
);
  import itot_pkg::*;

  localparam int unsigned TW     = $clog2(TICK_PERIOD_US + 1);
  localparam int unsigned PROD_W = 48 + TW;
  localparam logic [TW-1:0] TICK = TW'(TICK_PERIOD_US);

  logic [15:0]       trip_cur_q;
  logic [31:0]       curve_q;
  logic [31:0]       cool_q;
  logic [31:0]       energy_q, energy_d;
  logic              latch_q, latch_d;
  logic [DEN_W-1:0]  rem_q;
  logic [DEN_W-1:0]  den_q;
  logic [31:0]       num_q;
  logic [31:0]       quo_q;
  logic [23:0]       ratio_q;
  logic [47:0]       sq_q;
  logic              above_q;
  logic [PROD_W-1:0] prod_q;
  logic              sat_q;
  result_t           res_q;

  logic [DEN_W:0]    div_t;
  logic [DEN_W:0]    div_diff;
  logic              div_ge;
  logic [47:0]       excess;
  logic [24+TW-1:0]  mul_lo;
  logic [24+TW-1:0]  mul_hi;
  logic [DEN_W-1:0]  den_prod;
  logic [DEN_W-1:0]  num_hi;
  logic [31:0]       num_lo;
  logic [31:0]       step;
  logic [32:0]       heat_sum;

  assign div_t    = {rem_q, num_q[31]};
  assign div_diff = div_t - {1'b0, den_q};
  assign div_ge   = div_t >= {1'b0, den_q};

  assign excess   = {sq_q[47:32] - 16'd1, sq_q[31:0]};
  assign mul_lo   = (24+TW)'(excess[23:0]) * (24+TW)'(TICK);
  assign mul_hi   = (24+TW)'(excess[47:24]) * (24+TW)'(TICK);
  assign den_prod = DEN_W'(US_PER_S) * DEN_W'(above_q ? curve_q : cool_q);

  always_comb begin
    if (above_q) begin
      num_hi = DEN_W'(prod_q[PROD_W-1:16]);
      num_lo = {prod_q[15:0], 16'd0};
    end else begin
      num_hi = DEN_W'({TICK, 16'd0});
      num_lo = 32'd0;
    end
  end

  assign step     = sat_q ? ENERGY_ONE : quo_q;
  assign heat_sum = {1'b0, energy_q} + {1'b0, step};

  always_comb begin
    energy_d = energy_q;
    latch_d  = latch_q;
    if (!latch_q) begin
      if (above_q) begin
        if (heat_sum >= {1'b0, ENERGY_ONE}) begin
          energy_d = ENERGY_ONE;
          latch_d  = 1'b1;
        end else begin
          energy_d = heat_sum[31:0];
        end
      end else begin
        energy_d = (energy_q > step) ? energy_q - step : 32'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trip_cur_q <= TRIP_CURRENT_RST;
      curve_q    <= CURVE_CONSTANT_RST;
      cool_q     <= COOL_TIME_RST;
      energy_q   <= 32'd0;
      latch_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TRIP_CURRENT:   trip_cur_q <= cfg_data_i[15:0];
          CFG_CURVE_CONSTANT: curve_q    <= cfg_data_i;
          CFG_COOL_TIME:      cool_q     <= cfg_data_i;
          default: ;
        endcase
      end
      if (op_i == OP_UPDATE) begin
        energy_q <= energy_d;
        latch_q  <= latch_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        rem_q <= '0;
        num_q <= {sample_i.current_sample, 16'd0};
        den_q <= DEN_W'(trip_cur_q);
        quo_q <= '0;
      end
      OP_DIV: begin
        rem_q <= div_ge ? div_diff[DEN_W-1:0] : div_t[DEN_W-1:0];
        num_q <= {num_q[30:0], 1'b0};
        quo_q <= {quo_q[30:0], div_ge};
      end
      OP_RATIO: begin
        ratio_q <= (quo_q > {8'd0, RATIO_MAX}) ? RATIO_MAX : quo_q[23:0];
      end
      OP_SQUARE: begin
        sq_q    <= 48'(ratio_q) * 48'(ratio_q);
        above_q <= ratio_q > PICKUP_Q816;
      end
      OP_MUL_LO: begin
        prod_q <= PROD_W'(mul_lo);
        den_q  <= den_prod;
      end
      OP_MUL_HI: begin
        prod_q <= prod_q + {mul_hi, 24'd0};
      end
      OP_SETUP: begin
        sat_q <= num_hi >= den_q;
        rem_q <= num_hi;
        num_q <= num_lo;
        quo_q <= '0;
      end
      OP_UPDATE: begin
        res_q.tripped      <= latch_d;
        res_q.energy_level <= energy_d;
        res_q.above_pickup <= above_q & ~latch_q;
      end
      default: ;
    endcase
  end

  assign status_o.tripped = latch_q;
  assign result_o         = res_q;

endmodule

>>> rtl/core/itot_ctrl.sv
// Controller of the overload trip core: sequences the datapath through one item
// and owns the input ready and output valid handshake.
// Depends on itot_pkg; drives itot_dpath.
module itot_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  itot_pkg::dp_status_t status_i,
  output itot_pkg::dp_op_e     op_o
);
  import itot_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDIV,
    S_RATIO,
    S_SQUARE,
    S_MUL_LO,
    S_MUL_HI,
    S_SETUP,
    S_EDIV,
    S_FINISH
  } state_e;

  state_e     state_q;
  logic [4:0] cnt_q;
  logic       out_valid_q;
  logic       accept;
  logic       update;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_ready_o && in_valid_i;
  assign update      = (state_q == S_FINISH) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    case (state_q)
      S_IDLE:   op_o = accept ? OP_LOAD : OP_NONE;
      S_RDIV:   op_o = OP_DIV;
      S_RATIO:  op_o = OP_RATIO;
      S_SQUARE: op_o = OP_SQUARE;
      S_MUL_LO: op_o = OP_MUL_LO;
      S_MUL_HI: op_o = OP_MUL_HI;
      S_SETUP:  op_o = OP_SETUP;
      S_EDIV:   op_o = OP_DIV;
      S_FINISH: op_o = update ? OP_UPDATE : OP_NONE;
      default:  op_o = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (update) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cnt_q   <= 5'(RATIO_ITER - 1);
            state_q <= status_i.tripped ? S_FINISH : S_RDIV;
          end
        end
        S_RDIV: begin
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == 5'd0) state_q <= S_RATIO;
        end
        S_RATIO:  state_q <= S_SQUARE;
        S_SQUARE: state_q <= S_MUL_LO;
        S_MUL_LO: state_q <= S_MUL_HI;
        S_MUL_HI: state_q <= S_SETUP;
        S_SETUP: begin
          cnt_q   <= 5'(ENERGY_ITER - 1);
          state_q <= S_EDIV;
        end
        S_EDIV: begin
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == 5'd0) state_q <= S_FINISH;
        end
        S_FINISH: begin
          if (update) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/inverse_time_overload_trip_core.sv
// Top level of the inverse-time overload trip core.
// Joins itot_ctrl and itot_dpath; depends on itot_pkg and itot_stream_if.
//
//   channel    direction  payload                                   handshake
//   sample_i   in         current_sample                            valid/ready
//   result_o   out        tripped, energy_level, above_pickup       valid/ready
//   cfg_*_i    in         register index, write data                write enable
//
// From acceptance to result an item passes one load, 32 ratio iterations
// and 31 energy iterations of the shared one-bit-per-cycle restoring
// divider, the ratio clamp, square, low and high multiply and setup steps
// and one update, or once tripped only the update. Reset restores the register
// defaults and clears energy and the trip latch. A result waits in the output
// register; the next item is accepted meanwhile and held before its update.
module inverse_time_overload_trip_core #(
  parameter int unsigned TICK_PERIOD_US = 10000
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  itot_stream_if.sink                     sample_i,
  itot_stream_if.source                   result_o,
  input  logic                            cfg_we_i,
  input  logic [itot_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [itot_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import itot_pkg::*;

  dp_op_e     op;
  dp_status_t status;
  result_t    result;
  sample_t    sample;

  assign sample        = sample_i.data;
  assign result_o.data = result;

  itot_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .status_i    (status),
    .op_o        (op)
  );

  itot_dpath #(
    .TICK_PERIOD_US (TICK_PERIOD_US)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .sample_i   (sample),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .status_o   (status),
    .result_o   (result)
  );

endmodule
